// ----- hw/rtl/vertex_angle_three_points_unit_defines.svh -----
// Assertion macros shared by the vertex angle RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef VERTEX_ANGLE_THREE_POINTS_UNIT_DEFINES_SVH
`define VERTEX_ANGLE_THREE_POINTS_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VAQ_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vaq: implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define VAQ_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vaq: next-cycle check failed");

`endif

// ----- hw/rtl/vaq_pkg.sv -----
// Package for the vertex angle unit: request, response and control types,
// fixed-point constants and the CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vaq_pkg;

   localparam int COORD_BITS = 20;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int NORM_W     = 16;
   localparam int XY_W       = 20;
   localparam int Z_W        = 20;
   localparam int CORDIC_N   = 16;

   localparam logic [20:0] NORM_LIMIT      = 21'd32768;
   localparam logic [16:0] ONE_Q16         = 17'd65536;
   localparam logic signed [Z_W-1:0] HALF_PI_Q16 = 20'sd102944;
   localparam logic [21:0] DEG_PER_RAD_Q16 = 22'd3754939;
   localparam logic [15:0] ANGLE_MAX       = 16'd46080;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] first_x;
      logic signed [COORD_BITS-1:0] first_y;
      logic signed [COORD_BITS-1:0] first_z;
      logic signed [COORD_BITS-1:0] vertex_x;
      logic signed [COORD_BITS-1:0] vertex_y;
      logic signed [COORD_BITS-1:0] vertex_z;
      logic signed [COORD_BITS-1:0] second_x;
      logic signed [COORD_BITS-1:0] second_y;
      logic signed [COORD_BITS-1:0] second_z;
   } req_type;

   typedef struct packed {
      logic [15:0] angle_degrees;
      logic        degenerate_error;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic degen;
   } ctl_type;

   function automatic logic signed [Z_W-1:0] atan_q16(input int step);
      logic signed [Z_W-1:0] v;
      unique case (step)
         0:  v = 20'sd51472;
         1:  v = 20'sd30386;
         2:  v = 20'sd16055;
         3:  v = 20'sd8150;
         4:  v = 20'sd4091;
         5:  v = 20'sd2047;
         6:  v = 20'sd1024;
         7:  v = 20'sd512;
         8:  v = 20'sd256;
         9:  v = 20'sd128;
         10: v = 20'sd64;
         11: v = 20'sd32;
         12: v = 20'sd16;
         13: v = 20'sd8;
         14: v = 20'sd4;
         15: v = 20'sd2;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/vaq_sqrt_cell.sv -----
// One cell of the pipelined integer square root: resolves one root bit.
// Depends on vaq_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none
module vaq_sqrt_cell
   import vaq_pkg::*;
#(
   parameter int W      = 64,
   parameter int STEP   = 31,
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ctl_type           prev_ctl,
   input  wire logic [W-1:0]      prev_rem,
   input  wire logic [W-1:0]      prev_res,
   input  wire logic [SIDE_W-1:0] prev_side,
   output ctl_type                ctl_ff,
   output logic [W-1:0]           rem_ff,
   output logic [W-1:0]           res_ff,
   output logic [SIDE_W-1:0]      side_ff
);

   localparam logic [W-1:0] BIT = {{(W-1){1'b0}}, 1'b1} << (2 * STEP);

   logic [W:0]   trial;
   logic         take;
   logic [W-1:0] rem_in;
   logic [W-1:0] res_in;

   always_comb begin
      trial  = {1'b0, prev_res} + {1'b0, BIT};
      take   = ({1'b0, prev_rem} >= trial);
      rem_in = take ? (prev_rem - trial[W-1:0]) : prev_rem;
      res_in = take ? ((prev_res >> 1) + BIT) : (prev_res >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= prev_ctl;
      end
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      side_ff <= prev_side;
   end

endmodule
`default_nettype wire

// ----- hw/rtl/vaq_div_cell.sv -----
// One cell of the pipelined restoring divider: resolves one quotient bit.
// Depends on vaq_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none
module vaq_div_cell
   import vaq_pkg::*;
#(
   parameter int DW     = 50,
   parameter int VW     = 32,
   parameter int QW     = 17,
   parameter int STEP   = 16,
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ctl_type           prev_ctl,
   input  wire logic [DW-1:0]     prev_rem,
   input  wire logic [VW-1:0]     prev_div,
   input  wire logic [QW-1:0]     prev_q,
   input  wire logic [SIDE_W-1:0] prev_side,
   output ctl_type                ctl_ff,
   output logic [DW-1:0]          rem_ff,
   output logic [VW-1:0]          div_ff,
   output logic [QW-1:0]          q_ff,
   output logic [SIDE_W-1:0]      side_ff
);

   localparam logic [QW-1:0] QBIT = {{(QW-1){1'b0}}, 1'b1} << STEP;

   logic [DW-1:0] shifted;
   logic          take;
   logic [DW-1:0] rem_in;
   logic [QW-1:0] q_in;

   always_comb begin
      shifted = {{(DW-VW){1'b0}}, prev_div} << STEP;
      take    = (prev_rem >= shifted);
      rem_in  = take ? (prev_rem - shifted) : prev_rem;
      q_in    = take ? (prev_q | QBIT) : prev_q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= prev_ctl;
      end
      rem_ff  <= rem_in;
      div_ff  <= prev_div;
      q_ff    <= q_in;
      side_ff <= prev_side;
   end

endmodule
`default_nettype wire

// ----- hw/rtl/vaq_cordic_cell.sv -----
// One vectoring CORDIC rotation cell with a fixed shift and angle.
// Depends on vaq_pkg for widths, the control struct and the atan table.
`timescale 1ns / 1ps
`default_nettype none
module vaq_cordic_cell
   import vaq_pkg::*;
#(
   parameter int STEP = 0
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ctl_type                prev_ctl,
   input  wire logic signed [XY_W-1:0] prev_x,
   input  wire logic signed [XY_W-1:0] prev_y,
   input  wire logic signed [Z_W-1:0]  prev_z,
   output ctl_type                     ctl_ff,
   output logic signed [XY_W-1:0]      x_ff,
   output logic signed [XY_W-1:0]      y_ff,
   output logic signed [Z_W-1:0]       z_ff
);

   localparam logic signed [Z_W-1:0] ANGLE = atan_q16(STEP);

   logic signed [XY_W-1:0] xs;
   logic signed [XY_W-1:0] ys;
   logic signed [XY_W-1:0] x_in;
   logic signed [XY_W-1:0] y_in;
   logic signed [Z_W-1:0]  z_in;

   always_comb begin
      xs = prev_x >>> STEP;
      ys = prev_y >>> STEP;
      if (!prev_y[XY_W-1]) begin
         x_in = prev_x + ys;
         y_in = prev_y - xs;
         z_in = prev_z + ANGLE;
      end else begin
         x_in = prev_x - ys;
         y_in = prev_y + xs;
         z_in = prev_z - ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= prev_ctl;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

endmodule
`default_nettype wire

// ----- hw/rtl/vertex_angle_three_points_unit.sv -----
// Top level of the vertex angle unit: angle at a vertex between two 3-D points.
// Depends on vaq_pkg, vaq_sqrt_cell, vaq_div_cell, vaq_cordic_cell and the defines.
//
//   Channel   Ports                          Handshake
//   request   start, busy, req_payload       taken when start is high, busy low
//   response  rsp_valid, rsp_payload         one-cycle strobe, no back-pressure
//
// The pipeline holds 92 register stages: five setup stages, a 32-cell square root
// of |v1|^2*|v2|^2, one divide prep, a 17-cell divider, one sine prep, a 17-cell
// square root, one CORDIC start, a 16-cell CORDIC and two scaling stages.
// A new request enters every cycle. Reset clears only the per-stage control bits;
// busy is always low, and since the receiver cannot stall nothing ever holds.
`timescale 1ns / 1ps
`default_nettype none
`include "vertex_angle_three_points_unit_defines.svh"
module vertex_angle_three_points_unit
   import vaq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   output rsp_type      rsp_payload
);

   localparam int SQ1_N = 32;
   localparam int DIV_N = 17;
   localparam int SQ2_N = 17;

   // The pipeline never stalls, so it can always take a request.
   assign busy = 1'b0;

   // Magnitude shift that brings the largest component below 2^15.
   function automatic logic [2:0] norm_shift(input logic [DIFF_W-1:0] mx);
      logic [2:0] s;
      s = 3'd0;
      for (int k = 6; k >= 0; k--) begin
         if ((mx >> k) < NORM_LIMIT) begin
            s = 3'(k);
         end
      end
      return s;
   endfunction

   function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] d);
      return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
   endfunction

   // Truncate the magnitude toward zero and restore the sign.
   function automatic logic signed [NORM_W-1:0] norm_comp(
      input logic signed [DIFF_W-1:0] d, input logic [2:0] s);
      logic [DIFF_W-1:0] m;
      logic [NORM_W-1:0] mm;
      m  = abs_diff(d) >> s;
      mm = {1'b0, m[NORM_W-2:0]};
      return d[DIFF_W-1] ? NORM_W'(-mm) : NORM_W'(mm);
   endfunction

   // ---------------------------------------------------------------- stage 1
   // Difference vectors from the vertex and zero-length detection.
   ctl_type                    st1_ctl_ff;
   logic signed [DIFF_W-1:0]   d1_ff [3];
   logic signed [DIFF_W-1:0]   d2_ff [3];
   logic signed [DIFF_W-1:0]   d1_in [3];
   logic signed [DIFF_W-1:0]   d2_in [3];
   logic                       degen_in;

   always_comb begin
      d1_in[0] = DIFF_W'(req_payload.first_x) - DIFF_W'(req_payload.vertex_x);
      d1_in[1] = DIFF_W'(req_payload.first_y) - DIFF_W'(req_payload.vertex_y);
      d1_in[2] = DIFF_W'(req_payload.first_z) - DIFF_W'(req_payload.vertex_z);
      d2_in[0] = DIFF_W'(req_payload.second_x) - DIFF_W'(req_payload.vertex_x);
      d2_in[1] = DIFF_W'(req_payload.second_y) - DIFF_W'(req_payload.vertex_y);
      d2_in[2] = DIFF_W'(req_payload.second_z) - DIFF_W'(req_payload.vertex_z);
      degen_in = ((d1_in[0] == '0) && (d1_in[1] == '0) && (d1_in[2] == '0)) ||
                 ((d2_in[0] == '0) && (d2_in[1] == '0) && (d2_in[2] == '0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_ctl_ff <= '0;
      end else begin
         st1_ctl_ff.valid <= start && !busy;
         st1_ctl_ff.degen <= degen_in;
      end
      for (int k = 0; k < 3; k++) begin
         d1_ff[k] <= d1_in[k];
         d2_ff[k] <= d2_in[k];
      end
   end

   // ---------------------------------------------------------------- stage 2
   // Each vector is shifted on its own so that its components fit 16 bits.
   ctl_type                  st2_ctl_ff;
   logic signed [NORM_W-1:0] a_ff [3];
   logic signed [NORM_W-1:0] b_ff [3];
   logic [DIFF_W-1:0]        mx1;
   logic [DIFF_W-1:0]        mx2;
   logic [2:0]               s1;
   logic [2:0]               s2;

   always_comb begin
      mx1 = abs_diff(d1_ff[0]);
      mx2 = abs_diff(d2_ff[0]);
      for (int k = 1; k < 3; k++) begin
         if (abs_diff(d1_ff[k]) > mx1) begin
            mx1 = abs_diff(d1_ff[k]);
         end
         if (abs_diff(d2_ff[k]) > mx2) begin
            mx2 = abs_diff(d2_ff[k]);
         end
      end
      s1 = norm_shift(mx1);
      s2 = norm_shift(mx2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st2_ctl_ff <= '0;
      end else begin
         st2_ctl_ff <= st1_ctl_ff;
      end
      for (int k = 0; k < 3; k++) begin
         a_ff[k] <= norm_comp(d1_ff[k], s1);
         b_ff[k] <= norm_comp(d2_ff[k], s2);
      end
   end

   // ---------------------------------------------------------------- stage 3
   // Component products for the dot product and both squared lengths.
   ctl_type            st3_ctl_ff;
   logic signed [31:0] pd_ff [3];
   logic [29:0]        pa_ff [3];
   logic [29:0]        pb_ff [3];
   logic signed [31:0] sq_a [3];
   logic signed [31:0] sq_b [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq_a[k] = a_ff[k] * a_ff[k];
         sq_b[k] = b_ff[k] * b_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st3_ctl_ff <= '0;
      end else begin
         st3_ctl_ff <= st2_ctl_ff;
      end
      for (int k = 0; k < 3; k++) begin
         pd_ff[k] <= a_ff[k] * b_ff[k];
         pa_ff[k] <= sq_a[k][29:0];
         pb_ff[k] <= sq_b[k][29:0];
      end
   end

   // ---------------------------------------------------------------- stage 4
   ctl_type            st4_ctl_ff;
   logic signed [33:0] dot_ff;
   logic [31:0]        n1_ff;
   logic [31:0]        n2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st4_ctl_ff <= '0;
      end else begin
         st4_ctl_ff <= st3_ctl_ff;
      end
      dot_ff <= 34'(pd_ff[0]) + 34'(pd_ff[1]) + 34'(pd_ff[2]);
      n1_ff  <= 32'(pa_ff[0]) + 32'(pa_ff[1]) + 32'(pa_ff[2]);
      n2_ff  <= 32'(pb_ff[0]) + 32'(pb_ff[1]) + 32'(pb_ff[2]);
   end

   // ---------------------------------------------------------------- stage 5
   // Product of squared lengths, and the dot product split into sign and size.
   ctl_type     st5_ctl_ff;
   logic [63:0] prod_ff;
   logic [31:0] num_ff;
   logic        dneg_ff;
   logic [33:0] dot_abs;

   assign dot_abs = dot_ff[33] ? 34'(-dot_ff) : 34'(dot_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         st5_ctl_ff <= '0;
      end else begin
         st5_ctl_ff <= st4_ctl_ff;
      end
      prod_ff <= 64'(n1_ff) * 64'(n2_ff);
      num_ff  <= dot_abs[31:0];
      dneg_ff <= dot_ff[33];
   end

   // ------------------------------------------------- square root of product
   ctl_type     sq1_ctl  [SQ1_N+1];
   logic [63:0] sq1_rem  [SQ1_N+1];
   logic [63:0] sq1_res  [SQ1_N+1];
   logic [32:0] sq1_side [SQ1_N+1];

   assign sq1_ctl[0]  = st5_ctl_ff;
   assign sq1_rem[0]  = prod_ff;
   assign sq1_res[0]  = '0;
   assign sq1_side[0] = {dneg_ff, num_ff};

   for (genvar i = 0; i < SQ1_N; i++) begin : g_sq1
      vaq_sqrt_cell #(.W(64), .STEP(SQ1_N - 1 - i), .SIDE_W(33)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .prev_ctl  (sq1_ctl[i]),
         .prev_rem  (sq1_rem[i]),
         .prev_res  (sq1_res[i]),
         .prev_side (sq1_side[i]),
         .ctl_ff    (sq1_ctl[i+1]),
         .rem_ff    (sq1_rem[i+1]),
         .res_ff    (sq1_res[i+1]),
         .side_ff   (sq1_side[i+1])
      );
   end

   // ------------------------------------------------------------ divide prep
   // Rounded quotient: (num * 2^16 + r/2) / r, with r forced to at least one.
   ctl_type     dp_ctl_ff;
   logic [49:0] dp_dvd_ff;
   logic [31:0] dp_r_ff;
   logic        dp_neg_ff;
   logic [31:0] r_val;

   assign r_val = (sq1_res[SQ1_N][31:0] == '0) ? 32'd1 : sq1_res[SQ1_N][31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         dp_ctl_ff <= '0;
      end else begin
         dp_ctl_ff <= sq1_ctl[SQ1_N];
      end
      dp_dvd_ff <= {2'b00, sq1_side[SQ1_N][31:0], 16'h0000} + 50'(r_val >> 1);
      dp_r_ff   <= r_val;
      dp_neg_ff <= sq1_side[SQ1_N][32];
   end

   // ---------------------------------------------------------------- divider
   ctl_type     dv_ctl  [DIV_N+1];
   logic [49:0] dv_rem  [DIV_N+1];
   logic [31:0] dv_div  [DIV_N+1];
   logic [16:0] dv_q    [DIV_N+1];
   logic [0:0]  dv_side [DIV_N+1];

   assign dv_ctl[0]  = dp_ctl_ff;
   assign dv_rem[0]  = dp_dvd_ff;
   assign dv_div[0]  = dp_r_ff;
   assign dv_q[0]    = '0;
   assign dv_side[0] = dp_neg_ff;

   for (genvar i = 0; i < DIV_N; i++) begin : g_div
      vaq_div_cell #(.DW(50), .VW(32), .QW(17), .STEP(DIV_N - 1 - i), .SIDE_W(1)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .prev_ctl  (dv_ctl[i]),
         .prev_rem  (dv_rem[i]),
         .prev_div  (dv_div[i]),
         .prev_q    (dv_q[i]),
         .prev_side (dv_side[i]),
         .ctl_ff    (dv_ctl[i+1]),
         .rem_ff    (dv_rem[i+1]),
         .div_ff    (dv_div[i+1]),
         .q_ff      (dv_q[i+1]),
         .side_ff   (dv_side[i+1])
      );
   end

   // ------------------------------------------------------------ sine prep
   // Clamp the cosine magnitude to one and form 2^32 - c*c.
   ctl_type     cs_ctl_ff;
   logic [33:0] cs_rad_ff;
   logic [16:0] cs_cu_ff;
   logic        cs_neg_ff;
   logic [16:0] cu_val;

   assign cu_val = (dv_q[DIV_N] > ONE_Q16) ? ONE_Q16 : dv_q[DIV_N];

   always_ff @(posedge clock) begin
      if (reset) begin
         cs_ctl_ff <= '0;
      end else begin
         cs_ctl_ff <= dv_ctl[DIV_N];
      end
      cs_rad_ff <= 34'h1_0000_0000 - (34'(cu_val) * 34'(cu_val));
      cs_cu_ff  <= cu_val;
      cs_neg_ff <= dv_side[DIV_N][0];
   end

   // ------------------------------------------------------ square root of sine
   ctl_type     sq2_ctl  [SQ2_N+1];
   logic [33:0] sq2_rem  [SQ2_N+1];
   logic [33:0] sq2_res  [SQ2_N+1];
   logic [17:0] sq2_side [SQ2_N+1];

   assign sq2_ctl[0]  = cs_ctl_ff;
   assign sq2_rem[0]  = cs_rad_ff;
   assign sq2_res[0]  = '0;
   assign sq2_side[0] = {cs_neg_ff, cs_cu_ff};

   for (genvar i = 0; i < SQ2_N; i++) begin : g_sq2
      vaq_sqrt_cell #(.W(34), .STEP(SQ2_N - 1 - i), .SIDE_W(18)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .prev_ctl  (sq2_ctl[i]),
         .prev_rem  (sq2_rem[i]),
         .prev_res  (sq2_res[i]),
         .prev_side (sq2_side[i]),
         .ctl_ff    (sq2_ctl[i+1]),
         .rem_ff    (sq2_rem[i+1]),
         .res_ff    (sq2_res[i+1]),
         .side_ff   (sq2_side[i+1])
      );
   end

   // ---------------------------------------------------------- CORDIC start
   // An obtuse angle starts rotated by a quarter turn so the vector stays in
   // the right half plane.
   ctl_type                cd_ctl [CORDIC_N+1];
   logic signed [XY_W-1:0] cd_x   [CORDIC_N+1];
   logic signed [XY_W-1:0] cd_y   [CORDIC_N+1];
   logic signed [Z_W-1:0]  cd_z   [CORDIC_N+1];
   ctl_type                ci_ctl_ff;
   logic signed [XY_W-1:0] ci_x_ff;
   logic signed [XY_W-1:0] ci_y_ff;
   logic signed [Z_W-1:0]  ci_z_ff;
   logic [16:0]            sn_val;
   logic [16:0]            cu_mag;
   logic                   obtuse;

   always_comb begin
      sn_val = sq2_res[SQ2_N][16:0];
      cu_mag = sq2_side[SQ2_N][16:0];
      obtuse = sq2_side[SQ2_N][17] && (cu_mag != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ci_ctl_ff <= '0;
      end else begin
         ci_ctl_ff <= sq2_ctl[SQ2_N];
      end
      ci_x_ff <= obtuse ? XY_W'(sn_val) : XY_W'(cu_mag);
      ci_y_ff <= obtuse ? XY_W'(cu_mag) : XY_W'(sn_val);
      ci_z_ff <= obtuse ? HALF_PI_Q16 : '0;
   end

   assign cd_ctl[0] = ci_ctl_ff;
   assign cd_x[0]   = ci_x_ff;
   assign cd_y[0]   = ci_y_ff;
   assign cd_z[0]   = ci_z_ff;

   for (genvar i = 0; i < CORDIC_N; i++) begin : g_cordic
      vaq_cordic_cell #(.STEP(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .prev_ctl (cd_ctl[i]),
         .prev_x   (cd_x[i]),
         .prev_y   (cd_y[i]),
         .prev_z   (cd_z[i]),
         .ctl_ff   (cd_ctl[i+1]),
         .x_ff     (cd_x[i+1]),
         .y_ff     (cd_y[i+1]),
         .z_ff     (cd_z[i+1])
      );
   end

   // ------------------------------------------------------ radians to degrees
   ctl_type     dg_ctl_ff;
   logic [40:0] dg_prod_ff;
   logic [18:0] z_pos;

   assign z_pos = cd_z[CORDIC_N][Z_W-1] ? '0 : cd_z[CORDIC_N][18:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         dg_ctl_ff <= '0;
      end else begin
         dg_ctl_ff <= cd_ctl[CORDIC_N];
      end
      dg_prod_ff <= 41'(z_pos) * 41'(DEG_PER_RAD_Q16);
   end

   // Round to Q8.8, clamp at 180 degrees; a degenerate request reads zero.
   logic [41:0] deg_sum;
   logic [17:0] deg_raw;
   logic [15:0] deg_val;

   always_comb begin
      deg_sum = 42'(dg_prod_ff) + 42'h80_0000;
      deg_raw = deg_sum[41:24];
      deg_val = (deg_raw > 18'(ANGLE_MAX)) ? ANGLE_MAX : deg_raw[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= dg_ctl_ff.valid;
      end
      rsp_payload.angle_degrees    <= dg_ctl_ff.degen ? '0 : deg_val;
      rsp_payload.degenerate_error <= dg_ctl_ff.degen;
   end

   // ------------------------------------------------------------ assertions
   `VAQ_ASSERT_NEXT(a_accept_enters, clock, reset, start && !busy, st1_ctl_ff.valid)
   `VAQ_ASSERT_IMPLY(a_cos_bounded, clock, reset, dv_ctl[DIV_N].valid, dv_q[DIV_N] <= ONE_Q16)
   `VAQ_ASSERT_IMPLY(a_degen_zero, clock, reset, rsp_valid && rsp_payload.degenerate_error, rsp_payload.angle_degrees == '0)
   `VAQ_ASSERT_IMPLY(a_angle_max, clock, reset, rsp_valid, rsp_payload.angle_degrees <= ANGLE_MAX)

endmodule
`default_nettype wire

// ----- verif/vertex_angle_checker.sv -----
// Checker for the vertex angle unit: predicts the angle of every accepted request
// and compares it with the response strobe. Depends on vaq_pkg.
`timescale 1ns / 1ps
module vertex_angle_checker
   import vaq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  rsp_type rsp_payload,
   output int      fail_count,
   output int      pending_count
);

   rsp_type angle_queue[$];

   localparam longint ATAN_TAB[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                       256, 128, 64, 32, 16, 8, 4, 2};

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // Scale a vector down until every component magnitude is below 2^15.
   function automatic void shrink(input longint d[3], output longint o[3]);
      longint unsigned mag[3];
      longint unsigned mx;
      int s;
      mx = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = (d[i] < 0) ? -d[i] : d[i];
         if (mag[i] > mx) mx = mag[i];
      end
      while (s < 40 && (mx >> s) >= 32768) s++;
      for (int i = 0; i < 3; i++)
         o[i] = (d[i] < 0) ? -longint'(mag[i] >> s) : longint'(mag[i] >> s);
   endfunction

   function automatic rsp_type predict_angle(input req_type p);
      rsp_type r;
      longint d1[3], d2[3], a[3], b[3];
      longint dot, n1, n2, x, y, z, t, xs, ys, c;
      longint unsigned rt, num, cu, sn, deg;
      bit zero1, zero2;
      d1[0] = longint'(p.first_x) - longint'(p.vertex_x);
      d1[1] = longint'(p.first_y) - longint'(p.vertex_y);
      d1[2] = longint'(p.first_z) - longint'(p.vertex_z);
      d2[0] = longint'(p.second_x) - longint'(p.vertex_x);
      d2[1] = longint'(p.second_y) - longint'(p.vertex_y);
      d2[2] = longint'(p.second_z) - longint'(p.vertex_z);
      zero1 = (d1[0] == 0 && d1[1] == 0 && d1[2] == 0);
      zero2 = (d2[0] == 0 && d2[1] == 0 && d2[2] == 0);
      r = '0;
      if (zero1 || zero2) begin
         r.degenerate_error = 1'b1;
         return r;
      end
      shrink(d1, a);
      shrink(d2, b);
      dot = 0; n1 = 0; n2 = 0;
      for (int i = 0; i < 3; i++) begin
         dot += a[i] * b[i];
         n1 += a[i] * a[i];
         n2 += b[i] * b[i];
      end
      rt = int_sqrt(longint'(n1) * longint'(n2));
      if (rt == 0) rt = 1;
      num = (dot < 0) ? -dot : dot;
      cu = ((num << 16) + (rt >> 1)) / rt;
      if (cu > 65536) cu = 65536;
      c = (dot < 0) ? -longint'(cu) : longint'(cu);
      sn = int_sqrt((64'd1 << 32) - cu * cu);
      if (c < 0) begin
         x = sn; y = -c; z = 102944;
      end else begin
         x = c; y = sn; z = 0;
      end
      // Arithmetic shifts on signed longint floor toward minus infinity.
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            t = x + ys; y = y - xs; z += ATAN_TAB[i];
         end else begin
            t = x - ys; y = y + xs; z -= ATAN_TAB[i];
         end
         x = t;
      end
      if (z < 0) z = 0;
      deg = (longint'(z) * 3754939 + (64'd1 << 23)) >> 24;
      if (deg > 46080) deg = 46080;
      r.angle_degrees = deg[15:0];
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (start && !busy) angle_queue.push_back(predict_angle(req_payload));
         if (rsp_valid) begin
            if (angle_queue.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp_payload);
               fail_count <= fail_count + 1;
            end else begin
               want = angle_queue.pop_front();
               if (want.angle_degrees !== rsp_payload.angle_degrees ||
                   want.degenerate_error !== rsp_payload.degenerate_error) begin
                  $display("%0t: mismatch expected angle %0d err %0d, actual angle %0d err %0d",
                           $time, want.angle_degrees, want.degenerate_error,
                           rsp_payload.angle_degrees, rsp_payload.degenerate_error);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= angle_queue.size();
      end
   end

endmodule

// ----- verif/tb.sv -----
// Testbench top for the vertex angle unit: drives directed and random point
// triples and gives the verdict. Depends on vaq_pkg and vertex_angle_checker.
`timescale 1ns / 1ps
module tb;
   import vaq_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_payload = '0;
   logic    rsp_valid;
   rsp_type rsp_payload;
   int      fail_count;
   int      pending_count;
   int      cycle_count = 0;

   // Slowest run: about 1800 requests with gaps, plus the drain of the pipeline.
   localparam int CYCLE_LIMIT = 200000;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   vertex_angle_three_points_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload)
   );

   vertex_angle_checker i_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // The watchdog ends a run that hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic logic signed [19:0] rand_coord(input int mode);
      case (mode)
         0: return 20'(int'($urandom_range(0, 64)) - 32);
         1: return 20'(int'($urandom_range(0, 8192)) - 4096);
         default: return 20'($urandom);
      endcase
   endfunction

   function automatic req_type rand_request();
      req_type p;
      int mode;
      mode = $urandom_range(0, 2);
      p.vertex_x = rand_coord(mode);
      p.vertex_y = rand_coord(mode);
      p.vertex_z = rand_coord(mode);
      p.first_x = rand_coord(mode);
      p.first_y = rand_coord(mode);
      p.first_z = rand_coord(mode);
      p.second_x = rand_coord(mode);
      p.second_y = rand_coord(mode);
      p.second_z = rand_coord(mode);
      case ($urandom_range(0, 19))
         0: begin   // The first point sits on the vertex.
            p.first_x = p.vertex_x; p.first_y = p.vertex_y; p.first_z = p.vertex_z;
         end
         1: begin   // Second point sits on the vertex.
            p.second_x = p.vertex_x; p.second_y = p.vertex_y; p.second_z = p.vertex_z;
         end
         2: begin   // Both points coincide, giving a zero angle.
            p.second_x = p.first_x; p.second_y = p.first_y; p.second_z = p.first_z;
         end
         3: begin   // Points mirrored through the vertex, near 180 degrees.
            p.second_x = 2 * p.vertex_x - p.first_x;
            p.second_y = 2 * p.vertex_y - p.first_y;
            p.second_z = 2 * p.vertex_z - p.first_z;
         end
         default: ;
      endcase
      return p;
   endfunction

   // Holds a request on the port until the edge that accepts it.
   task automatic send_request(input req_type p);
      req_payload <= p;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic idle_cycle();
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_points(input logic signed [19:0] f[3], input logic signed [19:0] v[3],
                              input logic signed [19:0] s[3]);
      req_type p;
      p = {f[0], f[1], f[2], v[0], v[1], v[2], s[0], s[1], s[2]};
      send_request(p);
   endtask

   localparam logic signed [19:0] CMAX = 20'sd524287;
   localparam logic signed [19:0] CMIN = -20'sd524288;

   initial begin
      bit quiet;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests: right angle, zero, straight, degenerate and extremes.
      send_points('{256, 0, 0}, '{0, 0, 0}, '{0, 256, 0});
      send_points('{256, 0, 0}, '{0, 0, 0}, '{512, 0, 0});
      send_points('{256, 0, 0}, '{0, 0, 0}, '{-256, 0, 0});
      send_points('{5, 6, 7}, '{5, 6, 7}, '{1, 2, 3});
      send_points('{1, 2, 3}, '{5, 6, 7}, '{5, 6, 7});
      send_points('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0});
      send_points('{CMAX, CMAX, CMAX}, '{CMIN, CMIN, CMIN}, '{CMAX, CMIN, CMAX});
      send_points('{CMIN, CMIN, CMIN}, '{CMAX, CMAX, CMAX}, '{CMIN, CMIN, CMIN});
      send_points('{CMAX, CMIN, 0}, '{0, 0, 0}, '{CMIN, CMAX, 0});
      send_points('{CMAX, 0, 0}, '{CMIN, 0, 0}, '{CMIN, 1, 0});
      send_points('{1, 0, 0}, '{0, 0, 0}, '{1, 1, 0});
      send_points('{1, 0, 0}, '{0, 0, 0}, '{-1, 1, 0});
      send_points('{CMAX, 1, 0}, '{0, 0, 0}, '{CMAX, 0, 0});
      send_points('{-20'sd1, -20'sd1, -20'sd1}, '{0, 0, 0}, '{1, 1, 1});
      send_points('{3, 4, 0}, '{0, 0, 0}, '{4, 3, 0});

      // Let everything drain before the random part.
      idle_cycle();
      while (pending_count != 0) @(posedge clock);

      for (int n = 0; n < 1750; n++) begin
         quiet = (n >= 600 && n < 900);
         if (n == 1200) begin
            idle_cycle();
            while (pending_count != 0) @(posedge clock);
         end
         while (!quiet && $urandom_range(0, 99) < 23) idle_cycle();
         send_request(rand_request());
      end
      start <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/vaq_pkg.sv
hw/rtl/vaq_sqrt_cell.sv
hw/rtl/vaq_div_cell.sv
hw/rtl/vaq_cordic_cell.sv
hw/rtl/vertex_angle_three_points_unit.sv
verif/vertex_angle_checker.sv
verif/tb.sv
